[design/multi_stack_engine_assert.svh]
// Assertion macros for the multi-stack engine checker.
// Each macro expects clk and arst_n in scope.
`ifndef MULTI_STACK_ENGINE_ASSERT_SVH
`define MULTI_STACK_ENGINE_ASSERT_SVH

// Plain property, disabled while reset is applied
`define MSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When cond holds, sig keeps its value into the next cycle
`define MSE_ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> $stable(sig)) else $error(msg);

`endif

[design/mse_pkg.sv]
// Shared constants, codes and the queue entry type of the multi-stack engine.
// No dependencies.
`timescale 1ns / 1ps
package mse_pkg;
	localparam int MAX_STACKS = 16;
	localparam int POOL_NODES = 1024;

	localparam int NODE_W = $clog2(POOL_NODES + 1);
	localparam int ADDR_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int SLOT_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int CNT_W  = $clog2(MAX_STACKS + 1);
	localparam int ID_W   = 5;
	localparam int VAL_W  = 64;
	localparam int ST_W   = 3;
	localparam int OP_W   = 2;

	localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(POOL_NODES);

	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd2;
	localparam logic [OP_W-1:0] OP_POP     = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_ID   = 3'd1;
	localparam logic [ST_W-1:0] ST_NOT_LIVE = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_ROOM  = 3'd4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	// Classified transaction as held in the queue
	typedef struct packed {
		logic                    is_create;
		logic                    is_destroy;
		logic                    is_push;
		logic                    is_pop;
		logic                    id_zero;
		logic                    id_over_max;
		logic [ID_W-1:0]         id;
		logic signed [VAL_W-1:0] value;
	} item_t;
endpackage

[design/mse_front.sv]
// Front end: accepts input transactions and classifies them for the queue.
// Depends on mse_pkg.
`timescale 1ns / 1ps
module mse_front (
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mse_pkg::OP_W-1:0]       operation,
	input  logic [mse_pkg::ID_W-1:0]       stack_number,
	input  logic signed [mse_pkg::VAL_W-1:0] push_value,
	input  logic                           q_full,
	output logic                           q_push,
	output mse_pkg::item_t                 q_item
);
	import mse_pkg::*;

	// Stall while the queue has no room
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// Decode the operation and pre-check the id range
	always_comb begin
		q_item             = '0;
		q_item.is_create   = (operation == OP_CREATE);
		q_item.is_destroy  = (operation == OP_DESTROY);
		q_item.is_push     = (operation == OP_PUSH);
		q_item.is_pop      = (operation == OP_POP);
		q_item.id_zero     = (stack_number == '0);
		q_item.id_over_max = (stack_number > ID_W'(MAX_STACKS));
		q_item.id          = stack_number;
		q_item.value       = push_value;
	end
endmodule

[design/mse_queue.sv]
// Short queue of classified transactions between front and back end.
// Depends on mse_pkg.
`timescale 1ns / 1ps
module mse_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mse_pkg::item_t wr_item,
	output logic           full,
	output logic           rd_valid,
	input  logic           rd_en,
	output mse_pkg::item_t rd_item
);
	import mse_pkg::*;

	item_t                 entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wptr_q;
	logic [QPTR_W-1:0]     rptr_q;
	logic [QPTR_W:0]       count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = entry_q[rptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (rd_en)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	// Store the payload
	always_ff @(posedge clk) begin
		if (wr_en)
			entry_q[wptr_q] <= wr_item;
	end
endmodule

[design/mse_back.sv]
// Back end: executes create, destroy, push and pop on the stack table and
// node pool, and holds the result register. Depends on mse_pkg.
`timescale 1ns / 1ps
module mse_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  mse_pkg::item_t                   q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mse_pkg::ST_W-1:0]         status,
	output logic [mse_pkg::ID_W-1:0]         new_stack_number,
	output logic signed [mse_pkg::VAL_W-1:0] popped_value
);
	import mse_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PUSH = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_WALK = 2'd3;

	logic [1:0]              state_q;
	logic [MAX_STACKS-1:0]   live_q;
	logic [NODE_W-1:0]       top_q [MAX_STACKS];
	logic [CNT_W-1:0]        listed_q;
	logic [NODE_W-1:0]       free_head_q;
	logic [NODE_W-1:0]       fresh_q;
	logic [NODE_W-1:0]       cur_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [VAL_W-1:0] value_q;

	logic                    out_valid_q;
	logic [ST_W-1:0]         status_q;
	logic [ID_W-1:0]         new_id_q;
	logic signed [VAL_W-1:0] popped_q;

	// Node pool
	logic signed [VAL_W-1:0] node_value_mem [POOL_NODES];
	logic [NODE_W-1:0]       node_below_mem [POOL_NODES];
	logic signed [VAL_W-1:0] rd_value_q;
	logic [NODE_W-1:0]       rd_below_q;

	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    wr_value_en;
	logic                    wr_below_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic signed [VAL_W-1:0] wr_value;
	logic [NODE_W-1:0]       wr_below;

	logic                    start;
	logic                    bad;
	logic [SLOT_W-1:0]       slot;
	logic [NODE_W-1:0]       cur_top;
	logic                    top_ok;
	logic                    free_ok;
	logic                    fresh_ok;
	logic                    below_ok;
	logic                    found;
	logic [SLOT_W-1:0]       found_idx;

	logic                    res_load;
	logic [ST_W-1:0]         res_status;
	logic [ID_W-1:0]         res_new;
	logic signed [VAL_W-1:0] res_popped;

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign new_stack_number = new_id_q;
	assign popped_value     = popped_q;

	// Decode the head transaction against the stack table
	assign start    = (state_q == S_IDLE) && q_valid && (!out_valid_q || !out_stall);
	assign q_pop    = start;
	assign bad      = q_item.id_zero || q_item.id_over_max ||
	                  (int'(q_item.id) > int'(listed_q));
	assign slot     = SLOT_W'(q_item.id - ID_W'(1));
	assign cur_top  = top_q[slot];
	assign top_ok   = (cur_top < NULL_NODE);
	assign free_ok  = (free_head_q < NULL_NODE);
	assign fresh_ok = (fresh_q < NULL_NODE);
	assign below_ok = (rd_below_q < NULL_NODE);

	// Find the lowest listed id that is not live
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = MAX_STACKS - 1; i >= 0; i--) begin
			if (i < int'(listed_q) && !live_q[i]) begin
				found     = 1'b1;
				found_idx = SLOT_W'(i);
			end
		end
	end

	// Steer the node memory and the result register
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_value_en = 1'b0;
		wr_below_en = 1'b0;
		wr_addr     = '0;
		wr_value    = value_q;
		wr_below    = free_head_q;
		res_load    = 1'b0;
		res_status  = ST_OK;
		res_new     = '0;
		res_popped  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					res_load = 1'b1;
					if (q_item.is_create) begin
						if (found)
							res_new = ID_W'(found_idx) + ID_W'(1);
						else if (int'(listed_q) < MAX_STACKS)
							res_new = ID_W'(listed_q) + ID_W'(1);
						else
							res_status = ST_NO_ROOM;
					end else if (bad) begin
						res_status = ST_BAD_ID;
					end else if (q_item.is_destroy) begin
						if (top_ok) begin
							res_load = 1'b0;
							rd_en    = 1'b1;
							rd_addr  = ADDR_W'(cur_top);
						end
					end else if (!live_q[slot]) begin
						res_status = ST_NOT_LIVE;
					end else if (q_item.is_push) begin
						if (free_ok) begin
							res_load = 1'b0;
							rd_en    = 1'b1;
							rd_addr  = ADDR_W'(free_head_q);
						end else if (fresh_ok) begin
							wr_value_en = 1'b1;
							wr_below_en = 1'b1;
							wr_addr     = ADDR_W'(fresh_q);
							wr_value    = q_item.value;
							wr_below    = cur_top;
						end else begin
							res_status = ST_NO_ROOM;
						end
					end else begin
						if (top_ok) begin
							res_load = 1'b0;
							rd_en    = 1'b1;
							rd_addr  = ADDR_W'(cur_top);
						end else begin
							res_status = ST_EMPTY;
						end
					end
				end
			end
			S_PUSH: begin
				wr_value_en = 1'b1;
				wr_below_en = 1'b1;
				wr_addr     = ADDR_W'(free_head_q);
				wr_value    = value_q;
				wr_below    = top_q[slot_q];
				res_load    = 1'b1;
			end
			S_POP: begin
				wr_below_en = 1'b1;
				wr_addr     = ADDR_W'(cur_q);
				wr_below    = free_head_q;
				res_load    = 1'b1;
				res_popped  = rd_value_q;
			end
			S_WALK: begin
				if (below_ok) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(rd_below_q);
				end else begin
					wr_below_en = 1'b1;
					wr_addr     = ADDR_W'(cur_q);
					wr_below    = free_head_q;
					res_load    = 1'b1;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Node memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_value_en)
			node_value_mem[wr_addr] <= wr_value;
		if (wr_below_en)
			node_below_mem[wr_addr] <= wr_below;
		if (rd_en) begin
			rd_value_q <= node_value_mem[rd_addr];
			rd_below_q <= node_below_mem[rd_addr];
		end
	end

	// Update the stack table, free list and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			for (int i = 0; i < MAX_STACKS; i++)
				top_q[i] <= NULL_NODE;
			listed_q    <= '0;
			free_head_q <= NULL_NODE;
			fresh_q     <= '0;
			cur_q       <= '0;
			slot_q      <= '0;
			value_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						slot_q  <= slot;
						value_q <= q_item.value;
						cur_q   <= cur_top;
						if (q_item.is_create) begin
							if (found) begin
								live_q[found_idx] <= 1'b1;
							end else if (int'(listed_q) < MAX_STACKS) begin
								live_q[SLOT_W'(listed_q)] <= 1'b1;
								top_q[SLOT_W'(listed_q)]  <= NULL_NODE;
								listed_q <= listed_q + CNT_W'(1);
							end
						end else if (!bad) begin
							if (q_item.is_destroy) begin
								if (top_ok) begin
									state_q <= S_WALK;
								end else begin
									top_q[slot]  <= NULL_NODE;
									live_q[slot] <= 1'b0;
									if (CNT_W'(slot) + CNT_W'(1) == listed_q)
										listed_q <= listed_q - CNT_W'(1);
								end
							end else if (live_q[slot]) begin
								if (q_item.is_push) begin
									if (free_ok) begin
										state_q <= S_PUSH;
									end else if (fresh_ok) begin
										top_q[slot] <= fresh_q;
										fresh_q     <= fresh_q + NODE_W'(1);
									end
								end else if (top_ok) begin
									state_q <= S_POP;
								end
							end
						end
					end
				end
				S_PUSH: begin
					free_head_q   <= rd_below_q;
					top_q[slot_q] <= free_head_q;
					state_q       <= S_IDLE;
				end
				S_POP: begin
					top_q[slot_q] <= rd_below_q;
					free_head_q   <= cur_q;
					state_q       <= S_IDLE;
				end
				S_WALK: begin
					if (below_ok) begin
						cur_q <= rd_below_q;
					end else begin
						free_head_q    <= top_q[slot_q];
						top_q[slot_q]  <= NULL_NODE;
						live_q[slot_q] <= 1'b0;
						if (CNT_W'(slot_q) + CNT_W'(1) == listed_q)
							listed_q <= listed_q - CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register: drop on take, load on completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			new_id_q    <= '0;
			popped_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (res_load) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status;
				new_id_q    <= res_new;
				popped_q    <= res_popped;
			end
		end
	end
endmodule

[design/multi_stack_engine.sv]
// Create, rejected transactions and pushes from never-used nodes finish in the
// idle state; push from the free list passes through S_PUSH, pop through S_POP,
// and destroy through S_WALK once per node in its chain. These extra states wait
// on the single registered read port of the node memory. A new transaction is
// taken only in the idle state. Reset clears the stack table, leaves the node
// memory unwritten.
`timescale 1ns / 1ps
module multi_stack_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [mse_pkg::OP_W-1:0]         operation,
	input  logic [mse_pkg::ID_W-1:0]         stack_number,
	input  logic signed [mse_pkg::VAL_W-1:0] push_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mse_pkg::ST_W-1:0]         status,
	output logic [mse_pkg::ID_W-1:0]         new_stack_number,
	output logic signed [mse_pkg::VAL_W-1:0] popped_value
);
	import mse_pkg::*;

	logic  q_push;
	logic  q_full;
	item_t q_wr_item;
	logic  q_valid;
	logic  q_pop;
	item_t q_rd_item;

	// Classify incoming transactions
	mse_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.stack_number (stack_number),
		.push_value   (push_value),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_wr_item)
	);

	// Decouple front and back
	mse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_item  (q_wr_item),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_item  (q_rd_item)
	);

	// Execute against the stacks and node pool
	mse_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_rd_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.new_stack_number (new_stack_number),
		.popped_value     (popped_value)
	);
endmodule

[design/mse_checker.sv]
// Port-level checks on the multi-stack engine results, bound to the top level.
// Depends on mse_pkg and multi_stack_engine_assert.svh.
`timescale 1ns / 1ps
`include "multi_stack_engine_assert.svh"
module mse_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [mse_pkg::OP_W-1:0]         operation,
	input logic [mse_pkg::ID_W-1:0]         stack_number,
	input logic signed [mse_pkg::VAL_W-1:0] push_value,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [mse_pkg::ST_W-1:0]         status,
	input logic [mse_pkg::ID_W-1:0]         new_stack_number,
	input logic signed [mse_pkg::VAL_W-1:0] popped_value
);
	import mse_pkg::*;

	// A stalled result keeps its popped value
	`MSE_ASSERT_HOLD(a_out_hold, out_valid && out_stall, popped_value, "stalled result changed")
	// Status codes stay within the defined set
	`MSE_ASSERT(a_status_range, !out_valid || status <= ST_NO_ROOM, "undefined status code")
	// A new id comes only with success and within the id table
	`MSE_ASSERT(a_new_id_ok, !out_valid || new_stack_number == '0 || (status == ST_OK && int'(new_stack_number) <= MAX_STACKS), "new id with failing status or beyond table")
	// A popped value comes only with success
	`MSE_ASSERT(a_pop_ok, !out_valid || popped_value == '0 || (status == ST_OK && new_stack_number == '0), "popped value on failing transaction")
endmodule

bind multi_stack_engine mse_checker u_mse_checker (.*);

[bench/multi_stack_engine_tb.sv]
// Self-checking bench for the multi-stack engine: directed and random transactions
// checked against a behavioural stack/node-pool predictor. Depends on mse_pkg.
`timescale 1ns / 1ps

class stack_pool_scoreboard;
	bit                    live [mse_pkg::MAX_STACKS];
	int                    top_node [mse_pkg::MAX_STACKS];
	int                    listed;
	logic signed [63:0]    node_val [mse_pkg::POOL_NODES];
	int                    node_dn [mse_pkg::POOL_NODES];
	int                    free_head;
	int                    fresh;
	logic [2:0]            exp_status [$];
	logic [4:0]            exp_new_id [$];
	logic signed [63:0]    exp_popped [$];
	int                    errors;
	int                    checked;

	function void clear();
		for (int i = 0; i < mse_pkg::MAX_STACKS; i++) begin
			live[i] = 0;
			top_node[i] = mse_pkg::POOL_NODES;
		end
		listed = 0;
		free_head = mse_pkg::POOL_NODES;
		fresh = 0;
		errors = 0;
		checked = 0;
	endfunction

	// Predict the result of one accepted transaction and queue it
	function void note_input(logic [1:0] op, logic [4:0] id, logic signed [63:0] val);
		logic [2:0]         st;
		logic [4:0]         nid;
		logic signed [63:0] pv;
		int                 i;
		int                 s;
		int                 n;
		st = mse_pkg::ST_OK;
		nid = '0;
		pv = '0;
		if (op == mse_pkg::OP_CREATE) begin
			for (i = 0; i < listed; i++)
				if (!live[i])
					break;
			if (i < listed) begin
				live[i] = 1;
				nid = 5'(i + 1);
			end else if (listed < mse_pkg::MAX_STACKS) begin
				live[listed] = 1;
				top_node[listed] = mse_pkg::POOL_NODES;
				listed++;
				nid = 5'(listed);
			end else
				st = mse_pkg::ST_NO_ROOM;
		end else if (id == 0 || id > listed) begin
			st = mse_pkg::ST_BAD_ID;
		end else begin
			s = id - 1;
			if (op == mse_pkg::OP_DESTROY) begin
				// splice whole chain onto the free list
				if (top_node[s] < mse_pkg::POOL_NODES) begin
					n = top_node[s];
					while (node_dn[n] < mse_pkg::POOL_NODES)
						n = node_dn[n];
					node_dn[n] = free_head;
					free_head = top_node[s];
				end
				top_node[s] = mse_pkg::POOL_NODES;
				live[s] = 0;
				if (s + 1 == listed)
					listed--;
			end else if (!live[s]) begin
				st = mse_pkg::ST_NOT_LIVE;
			end else if (op == mse_pkg::OP_PUSH) begin
				if (free_head < mse_pkg::POOL_NODES) begin
					n = free_head;
					free_head = node_dn[n];
				end else if (fresh < mse_pkg::POOL_NODES) begin
					n = fresh;
					fresh++;
				end else
					n = mse_pkg::POOL_NODES;
				if (n == mse_pkg::POOL_NODES)
					st = mse_pkg::ST_NO_ROOM;
				else begin
					node_val[n] = val;
					node_dn[n] = top_node[s];
					top_node[s] = n;
				end
			end else begin
				n = top_node[s];
				if (n == mse_pkg::POOL_NODES)
					st = mse_pkg::ST_EMPTY;
				else begin
					pv = node_val[n];
					top_node[s] = node_dn[n];
					node_dn[n] = free_head;
					free_head = n;
				end
			end
		end
		exp_status.push_back(st);
		exp_new_id.push_back(nid);
		exp_popped.push_back(pv);
	endfunction

	task report(string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// Compare one accepted result with the oldest prediction
	task check_result(logic [2:0] st, logic [4:0] nid, logic signed [63:0] pv);
		logic [2:0]         es;
		logic [4:0]         en;
		logic signed [63:0] ep;
		if (exp_status.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		es = exp_status.pop_front();
		en = exp_new_id.pop_front();
		ep = exp_popped.pop_front();
		checked++;
		if (st !== es)
			report($sformatf("status %0d, expected %0d", st, es));
		if (nid !== en)
			report($sformatf("new_stack_number %0d, expected %0d", nid, en));
		if (pv !== ep)
			report($sformatf("popped_value %0d, expected %0d", pv, ep));
	endtask

	function int pending();
		return exp_status.size();
	endfunction
endclass

module multi_stack_engine_tb;
	import mse_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [OP_W-1:0]    operation;
	logic [ID_W-1:0]    stack_number;
	logic signed [63:0] push_value;
	logic               out_valid;
	logic               out_stall;
	logic [ST_W-1:0]    status;
	logic [ID_W-1:0]    new_stack_number;
	logic signed [63:0] popped_value;

	stack_pool_scoreboard sb;
	int  cycles;
	int  sent;
	bit  calm;
	bit  hold_off;
	int  ops_seen [4];

	multi_stack_engine dut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_CREATE;
		stack_number = '0;
		push_value = '0;
		out_stall = 1'b0;
		calm = 1'b0;
		hold_off = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("** multi_stack_engine: FAILED **");
			$finish;
		end
	end
	initial cycles = 0;

	// Receive side: check results, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, new_stack_number, popped_value);
	end

	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	// Offer one transaction and hold it until accepted
	task send(logic [1:0] op, logic [4:0] id, logic signed [63:0] val);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		stack_number <= id;
		push_value <= val;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(op, id, val);
		ops_seen[op]++;
		sent++;
	endtask

	function logic signed [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly listed ids, sometimes anything
	function logic [4:0] rnd_id();
		if ($urandom_range(0, 9) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(1, sb.listed > 0 ? sb.listed : 1));
	endfunction

	initial begin
		int k;
		int op;
		sent = 0;
		@(posedge arst_n);
		@(posedge clk);
		// Directed: rejections on empty table, extremes, empty pop
		send(OP_PUSH, 5'd0, 64'sd1);
		send(OP_POP, 5'd31, 64'sd0);
		send(OP_DESTROY, 5'd1, 64'sd0);
		send(OP_CREATE, 5'd31, -64'sd1);
		send(OP_POP, 5'd1, 64'sd0);
		send(OP_PUSH, 5'd1, 64'h8000_0000_0000_0000);
		send(OP_PUSH, 5'd1, 64'h7fff_ffff_ffff_ffff);
		send(OP_PUSH, 5'd1, 64'sd0);
		send(OP_POP, 5'd1, 64'sd0);
		send(OP_CREATE, 5'd0, 64'sd0);
		send(OP_DESTROY, 5'd1, 64'sd0);
		send(OP_PUSH, 5'd1, 64'sd5);
		send(OP_POP, 5'd1, 64'sd0);
		send(OP_CREATE, 5'd0, 64'sd0);
		send(OP_PUSH, 5'd2, -64'sd7);
		send(OP_DESTROY, 5'd2, 64'sd0);
		send(OP_DESTROY, 5'd1, 64'sd0);
		// Fill the id table to reach the full case
		for (k = 0; k < MAX_STACKS + 1; k++)
			send(OP_CREATE, 5'd0, 64'sd0);
		send(OP_DESTROY, 5'd16, 64'sd0);
		send(OP_PUSH, 5'd17, 64'sd0);
		// Exhaust the pool onto one stack, then release it
		for (k = 0; k < POOL_NODES + 2; k++)
			send(OP_PUSH, 5'd3, rnd64());
		send(OP_DESTROY, 5'd3, 64'sd0);
		send(OP_CREATE, 5'd0, 64'sd0);
		// Long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		for (k = 0; k < 40; k++)
			send(OP_PUSH, 5'd3, rnd64());
		// Random mix, push-heavy so stacks grow deep
		for (k = 0; k < 550; k++) begin
			if (k > 450)
				calm = 1'b1;
			op = $urandom_range(0, 99);
			if (op < 8)
				send(OP_CREATE, 5'($urandom()), rnd64());
			else if (op < 16)
				send(OP_DESTROY, rnd_id(), rnd64());
			else if (op < 60)
				send(OP_PUSH, rnd_id(), rnd64());
			else
				send(OP_POP, rnd_id(), rnd64());
		end
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d transactions (create %0d, destroy %0d, push %0d, pop %0d), %0d checked",
			sent, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], sb.checked);
		$display("pool exhaustion, full id table, idle stacks and a long output stall exercised");
		if (sb.errors == 0)
			$display("** multi_stack_engine: PASSED **");
		else
			$display("** multi_stack_engine: FAILED **");
		$finish;
	end
endmodule
